>>> hdl/qhup_pkg.sv
// Shared types, constants and AES helper functions for header unprotect.
package qhup_pkg;

   localparam int KeyWidth = 128;
   localparam int PnWidth = 62;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 64;
   localparam logic [CsrIndexWidth-1:0] CSR_HP_KEY_HIGH = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_HP_KEY_LOW = 1'b1;
   localparam int AesRounds = 10;

   typedef struct packed {
      logic [7:0]  first_byte;
      logic [31:0] pn_bytes_protected;
      logic [63:0] sample_high;
      logic [63:0] sample_low;
      logic [61:0] largest_pn;
   } req_type;

   typedef struct packed {
      logic [7:0]  first_byte_clear;
      logic [31:0] pn_bytes_clear;
      logic [2:0]  pn_length;
      logic        key_phase;
      logic        is_long_header;
      logic [1:0]  long_type;
      logic [63:0] packet_number;
   } rsp_type;

   // fields carried alongside the AES pipeline
   typedef struct packed {
      logic [7:0]  first_byte;
      logic [31:0] pn_bytes_protected;
      logic [61:0] largest_pn;
   } side_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block sits at bits 127-8i -: 8
   function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
      blk_byte = b[127-8*i -: 8];
   endfunction

   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      key_next = {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, x;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            t[127-8*(j+4*c) -: 8] = SBOX[blk_byte(s, j + 4*((c + j) % 4))];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = blk_byte(t, 4*c);
            a1 = blk_byte(t, 4*c+1);
            a2 = blk_byte(t, 4*c+2);
            a3 = blk_byte(t, 4*c+3);
            x = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c) -: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
         end
      end
      aes_round = t ^ rk;
   endfunction

endpackage

>>> hdl/qhup_aes_stage.sv
// One AES-128 round stage with its key expansion step and side payload.
module qhup_aes_stage
   import qhup_pkg::*;
#(
   parameter logic [7:0] RCON = 8'h01,
   parameter bit LAST = 1'b0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [127:0] in_state,
   input  logic [127:0] in_key,
   input  side_type     in_side,
   output logic         out_valid,
   output logic [127:0] out_state,
   output logic [127:0] out_key,
   output side_type     out_side
);

   logic         valid_ff;
   logic [127:0] state_ff, state_in, key_ff, key_in;
   side_type     side_ff;

   always_comb begin
      key_in = key_next(in_key, RCON);
      state_in = aes_round(in_state, key_in, LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      state_ff <= state_in;
      key_ff <= key_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key = key_ff;
   assign out_side = side_ff;

endmodule

>>> hdl/qhup_pn_decode.sv
// Unmask and packet number decode, two register stages.
module qhup_pn_decode
   import qhup_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [39:0]  in_mask,
   input  side_type     in_side,
   output logic         out_valid,
   output rsp_type      out_rsp
);

   logic        v1_ff, v2_ff;
   rsp_type     r1_ff, r1_in, r2_ff, r2_in;
   logic [63:0] exp1_ff, exp1_in, cand1_ff, cand1_in;
   logic [63:0] win, hwin, up, dn;
   logic [7:0]  fc;
   logic [31:0] pnc;
   logic [1:0]  len_code;
   logic        is_long;
   logic [31:0] trunc;
   logic [63:0] lowmask;

   always_comb begin
      is_long = in_side.first_byte[7];
      fc = in_side.first_byte ^ (in_mask[39:32] & (is_long ? 8'h0f : 8'h1f));
      pnc = in_side.pn_bytes_protected ^ in_mask[31:0];
      len_code = fc[1:0];
      trunc = pnc >> (5'd8 * (5'd3 - {3'd0, len_code}));
      lowmask = (64'd1 << (7'd8 * ({5'd0, len_code} + 7'd1))) - 64'd1;
      exp1_in = {2'b00, in_side.largest_pn} + 64'd1;
      cand1_in = (exp1_in & ~lowmask) | {32'd0, trunc};
      r1_in = '0;
      r1_in.first_byte_clear = fc;
      r1_in.pn_bytes_clear = pnc;
      r1_in.pn_length = {1'b0, len_code} + 3'd1;
      r1_in.key_phase = fc[2];
      r1_in.is_long_header = is_long;
      r1_in.long_type = is_long ? fc[5:4] : 2'b00;
   end

   always_comb begin
      win = 64'd1 << (7'd8 * {4'd0, r1_ff.pn_length});
      hwin = win >> 1;
      up = cand1_ff + win;
      dn = cand1_ff - win;
      r2_in = r1_ff;
      if ((cand1_ff + hwin <= exp1_ff) && (up < (64'd1 << 62))) begin
         r2_in.packet_number = up;
      end else if ((cand1_ff > exp1_ff + hwin) && (cand1_ff >= win)) begin
         r2_in.packet_number = dn;
      end else begin
         r2_in.packet_number = cand1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      r1_ff <= r1_in;
      exp1_ff <= exp1_in;
      cand1_ff <= cand1_in;
      r2_ff <= r2_in;
   end

   assign out_valid = v2_ff;
   assign out_rsp = r2_ff;

endmodule

>>> hdl/quic_header_unprotect_pn_decode.sv
// Top level: QUIC header protection removal and packet number decode.
// An item is taken in every cycle that start is high and busy is low; busy is
// tied low. Each result appears on rsp_data with rsp_valid high for one cycle,
// once its item has passed one input register, ten AES round stages with
// on-the-fly key expansion, then an unmask stage and a window decode stage.
// The receiver cannot stall; results are never held. Write the key only
// while no item is in flight.
module quic_header_unprotect_pn_decode
   import qhup_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam logic [7:0] RCON [AesRounds] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic [63:0]  key_high_ff, key_low_ff;
   logic         v0_ff;
   logic [127:0] s0_ff;
   side_type     side0_ff;

   logic         vld   [AesRounds+1];
   logic [127:0] st    [AesRounds+1];
   logic [127:0] rk    [AesRounds+1];
   side_type     sd    [AesRounds+1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         if (csr_write && csr_index == CSR_HP_KEY_HIGH) begin
            key_high_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_HP_KEY_LOW) begin
            key_low_ff <= csr_data;
         end
      end
      s0_ff <= {req_data.sample_high, req_data.sample_low}
               ^ {key_high_ff, key_low_ff};
      side0_ff <= '{first_byte: req_data.first_byte,
                    pn_bytes_protected: req_data.pn_bytes_protected,
                    largest_pn: req_data.largest_pn};
   end

   assign vld[0] = v0_ff;
   assign st[0] = s0_ff;
   assign rk[0] = {key_high_ff, key_low_ff};
   assign sd[0] = side0_ff;

   for (genvar r = 0; r < AesRounds; r++) begin : g_round
      qhup_aes_stage #(
         .RCON (RCON[r]),
         .LAST (r == AesRounds - 1)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[r]),
         .in_state  (st[r]),
         .in_key    (rk[r]),
         .in_side   (sd[r]),
         .out_valid (vld[r+1]),
         .out_state (st[r+1]),
         .out_key   (rk[r+1]),
         .out_side  (sd[r+1])
      );
   end

   qhup_pn_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[AesRounds]),
      .in_mask   (st[AesRounds][127:88]),
      .in_side   (sd[AesRounds]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pn_length != 3'd0 && rsp_data.pn_length <= 3'd4))
      else $error("pn_length out of range");
   a_short_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_long_header |-> rsp_data.long_type == 2'b00)
      else $error("long_type set on short header");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 13))
      else $error("result without item");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(start, 13) |-> !rsp_valid)
      else $error("spurious result");

endmodule
